// ----- design/hiopc_pkg.sv -----
package hiopc_pkg;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_KEY   = 3'd2,
    OP_ON    = 3'd3,
    OP_TIMER = 3'd4
  } opcode_t;

  localparam logic [7:0] PORT_MASK = 8'h17;
  localparam logic [7:0] P_LINK    = 8'h00;
  localparam logic [7:0] P_ROWS    = 8'h01;
  localparam logic [7:0] P_PAGE    = 8'h02;
  localparam logic [7:0] P_INT     = 8'h03;
  localparam logic [7:0] P_MODE    = 8'h04;
  localparam logic [7:0] P_LINK_B  = 8'h14;
  localparam logic [7:0] P_ROWS_A  = 8'h05;
  localparam logic [7:0] P_ROWS_B  = 8'h15;
  localparam logic [7:0] P_PAGE_A  = 8'h06;
  localparam logic [7:0] P_PAGE_B  = 8'h16;
  localparam logic [7:0] P_INT_A   = 8'h07;
  localparam logic [7:0] P_INT_B   = 8'h17;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] port;
    logic [7:0] val;
    logic [7:0] km;
    logic       pressed;
    logic       tsel;
    logic       halted;
    logic [1:0] partner;
  } req_t;

  function automatic logic [7:0] default_key(input logic [6:0] c);
    logic [7:0] r;
    r = 8'hff;
    case (c)
      7'd1: r = 8'h66;  7'd2: r = 8'h41;  7'd3: r = 8'h31;  7'd4: r = 8'h21;
      7'd5: r = 8'h42;  7'd6: r = 8'h32;  7'd7: r = 8'h22;  7'd8: r = 8'h43;
      7'd9: r = 8'h33;  7'd10: r = 8'h23; 7'd11: r = 8'h40; 7'd12: r = 8'h20;
      7'd13: r = 8'h47; 7'd16: r = 8'h23; 7'd17: r = 8'h12; 7'd18: r = 8'h45;
      7'd19: r = 8'h13; 7'd20: r = 8'h42; 7'd21: r = 8'h41; 7'd22: r = 8'h32;
      7'd23: r = 8'h54; 7'd24: r = 8'h43; 7'd25: r = 8'h33; 7'd26: r = 8'h34;
      7'd27: r = 8'h24; 7'd28: r = 8'h10; 7'd29: r = 8'h57; 7'd30: r = 8'h56;
      7'd31: r = 8'h52; 7'd32: r = 8'h55; 7'd33: r = 8'h35; 7'd34: r = 8'h25;
      7'd35: r = 8'h15; 7'd36: r = 8'h44; 7'd37: r = 8'h34; 7'd38: r = 8'h24;
      7'd42: r = 8'h65; 7'd44: r = 8'h31; 7'd45: r = 8'h51; 7'd46: r = 8'h36;
      7'd47: r = 8'h22; 7'd48: r = 8'h46; 7'd49: r = 8'h53; 7'd50: r = 8'h14;
      7'd51: r = 8'h44; 7'd52: r = 8'h30; 7'd53: r = 8'h14; 7'd54: r = 8'h16;
      7'd55: r = 8'h13; 7'd57: r = 8'h40; 7'd59: r = 8'h64; 7'd60: r = 8'h63;
      7'd61: r = 8'h62; 7'd62: r = 8'h61; 7'd63: r = 8'h60; 7'd71: r = 8'h56;
      7'd72: r = 8'h03; 7'd73: r = 8'h46; 7'd74: r = 8'h12; 7'd75: r = 8'h01;
      7'd77: r = 8'h02; 7'd78: r = 8'h11; 7'd79: r = 8'h37; 7'd80: r = 8'h00;
      7'd81: r = 8'h36; 7'd82: r = 8'h26; 7'd83: r = 8'h67;
      default: r = 8'hff;
    endcase
    return r;
  endfunction

endpackage

// ----- design/hiopc_front.sv -----
module hiopc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_port_number,
  input  logic [7:0]        in_write_value,
  input  logic [6:0]        in_key_code,
  input  logic              in_key_pressed,
  input  logic              in_key_raw,
  input  logic              in_timer_select,
  input  logic              in_cpu_halted,
  input  logic [1:0]        in_partner_lines,
  output logic              q_valid,
  output hiopc_pkg::req_t   q_req,
  input  logic              q_take
);
  import hiopc_pkg::*;

  // two-entry queue
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       req;
  logic       push_ok;

  always_comb begin
    req.op      = opcode_t'(in_opcode);
    req.port    = in_port_number & PORT_MASK;
    req.val     = in_write_value;
    req.km      = in_key_raw ? {1'b0, in_key_code} : default_key(in_key_code);
    req.pressed = in_key_pressed;
    req.tsel    = in_timer_select;
    req.halted  = in_cpu_halted;
    req.partner = in_partner_lines;
  end

  assign in_full = cnt_r[1];
  assign push_ok = in_push && !in_full;
  assign q_valid = cnt_r != 2'd0;
  assign q_req   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= req;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, q_take};
    end
  end
endmodule

// ----- design/hiopc_back.sv -----
module hiopc_back #(
  parameter int KEY_ROWS = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_link_variant,
  input  logic            q_valid,
  input  hiopc_pkg::req_t q_req,
  output logic            q_take,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_read_data,
  output logic [3:0]      out_bank_one,
  output logic [3:0]      out_bank_two,
  output logic [3:0]      out_bank_three,
  output logic            out_writable_one,
  output logic            out_writable_two,
  output logic            out_writable_three,
  output logic            out_interrupt_request
);
  import hiopc_pkg::*;

  logic       lv_r;
  logic [7:0] rows_r [KEY_ROWS];
  logic [7:0] rmask_r, page_r;
  logic [3:0] ie_r, ip_r, lmask_r;
  logic       on_r, mode_r;
  logic [1:0] own_r;
  logic       ov_r;

  logic [7:0] rows_nxt [KEY_ROWS];
  logic [7:0] rmask_nxt, page_nxt, rd_nxt, t, rowand;
  logic [3:0] ie_nxt, ip_nxt, lmask_nxt;
  logic       on_nxt, mode_nxt;
  logic [1:0] own_nxt;
  logic [3:0] p1, p2, b1, b2, b3;
  logic       m1, m2, w1, w2, w3;
  logic [3:0] rowidx;

  assign out_empty = !ov_r;
  assign q_take = q_valid && (!ov_r || out_pop);

  always_comb begin
    rows_nxt = rows_r;
    rmask_nxt = rmask_r; page_nxt = page_r; ie_nxt = ie_r; ip_nxt = ip_r;
    lmask_nxt = lmask_r; on_nxt = on_r; mode_nxt = mode_r; own_nxt = own_r;
    rd_nxt = 8'h00; t = 8'h00;
    rowidx = q_req.km[7:4];
    rowand = 8'hff;
    for (int i = 0; i < KEY_ROWS; i++)
      if (!rmask_r[i]) rowand = rowand & rows_r[i];
    case (q_req.op)
      OP_WRITE: begin
        unique case (q_req.port)
          P_LINK: begin
            if (lv_r) own_nxt = ~q_req.val[1:0];
            else begin
              lmask_nxt = q_req.val[7:4];
              t = ~q_req.val | {4'h0, ~q_req.val[7:4]};
              own_nxt = t[1:0] & t[3:2];
            end
          end
          P_ROWS: rmask_nxt = (q_req.val == 8'hff) ? 8'hff : (rmask_r & q_req.val);
          P_PAGE: page_nxt = q_req.val;
          P_INT: begin
            ie_nxt = q_req.val[3:0];
            ip_nxt = ip_r & q_req.val[3:0];
          end
          P_MODE: mode_nxt = q_req.val[0];
          default: ;
        endcase
      end
      OP_READ: begin
        unique case (q_req.port)
          P_LINK, P_MODE, P_LINK_B: begin
            if (lv_r) rd_nxt = {4'h0, own_r & q_req.partner, own_r};
            else rd_nxt = {lmask_r,
                           {own_r, own_r} & ({q_req.partner, q_req.partner} | lmask_r)};
          end
          P_ROWS, P_ROWS_A, P_ROWS_B: rd_nxt = rowand;
          P_PAGE, P_PAGE_A, P_PAGE_B: rd_nxt = page_r;
          P_INT, P_INT_A, P_INT_B:    rd_nxt = {4'h0, ip_r | {~on_r, 3'b000}};
          default: ;
        endcase
      end
      OP_KEY: begin
        if (rowidx < 4'(KEY_ROWS)) begin
          for (int i = 0; i < KEY_ROWS; i++)
            if (rowidx == 4'(i))
              rows_nxt[i][q_req.km[2:0]] = !q_req.pressed;
        end
      end
      OP_ON: begin
        if (q_req.pressed) begin
          if (!on_r) begin
            on_nxt = 1'b1;
            ip_nxt = ip_r | {3'b000, ie_r[0]};
          end
        end else on_nxt = 1'b0;
      end
      OP_TIMER: begin
        if (ie_r[3] || !q_req.halted)
          ip_nxt = ip_r | (ie_r & (q_req.tsel ? 4'h2 : 4'h4));
      end
      default: ;
    endcase
    m1 = page_nxt[7];
    p1 = {m1, 2'b00, page_nxt[3]};
    if (page_nxt[6]) begin
      p2 = {3'b100, page_nxt[0]}; m2 = 1'b1;
    end else begin
      p2 = {1'b0, page_nxt[2:0]}; m2 = 1'b0;
    end
    if (!mode_nxt) begin
      b1 = p2; b2 = p1; b3 = 4'd8; w1 = m2; w2 = m1; w3 = 1'b1;
    end else if (!page_nxt[6]) begin
      b1 = 4'd0; b2 = p2; b3 = p1; w1 = 1'b0; w2 = m2; w3 = m1;
    end else begin
      b1 = 4'd8; b2 = 4'd9; b3 = p1; w1 = 1'b1; w2 = 1'b1; w3 = m1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_read_data <= rd_nxt;
      out_bank_one <= b1; out_bank_two <= b2; out_bank_three <= b3;
      out_writable_one <= w1; out_writable_two <= w2; out_writable_three <= w3;
      out_interrupt_request <= ip_nxt != 4'h0;
    end
    if (!rst_n) begin
      lv_r <= 1'b0; ov_r <= 1'b0;
      for (int i = 0; i < KEY_ROWS; i++) rows_r[i] <= 8'hff;
      rmask_r <= 8'hff; page_r <= 8'h00; ie_r <= 4'h0; ip_r <= 4'h0;
      lmask_r <= 4'hc; on_r <= 1'b0; mode_r <= 1'b0; own_r <= 2'b00;
    end else begin
      if (cfg_we) lv_r <= cfg_link_variant;
      if (q_take) begin
        ov_r <= 1'b1;
        rows_r <= rows_nxt;
        rmask_r <= rmask_nxt; page_r <= page_nxt; ie_r <= ie_nxt; ip_r <= ip_nxt;
        lmask_r <= lmask_nxt; on_r <= on_nxt; mode_r <= mode_nxt; own_r <= own_nxt;
      end else if (out_pop) ov_r <= 1'b0;
    end
  end
endmodule

// ----- design/handheld_io_port_controller_core.sv -----
// Port and keypad controller of a handheld's processor bus.
// Requests enter through in_push/in_full, each with an opcode (port
// write, port read, key event, ON key event, timer fire) and its fields.
// Each request yields one result on out_* while out_empty is low, taken
// with out_pop: read data, the banks and writability of windows 1 to 3,
// and the interrupt line.
// A front stage decodes the port and translates the key code into a
// two-entry queue; the back stage applies the request to the state and
// loads the result register.
// A request queues, then loads the result. Throughput: one request per
// cycle while results are popped; a stalled result register holds and
// the queue absorbs two more requests before in_full rises.
// cfg_we/cfg_link_variant selects the link port variant; write it idle.
// Reset (rst_n low, synchronous) empties the queue and result register
// and restores the keypad, masks, interrupt and paging state.
module handheld_io_port_controller_core #(
  parameter int KEY_ROWS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_link_variant,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_port_number,
  input  logic [7:0] in_write_value,
  input  logic [6:0] in_key_code,
  input  logic       in_key_pressed,
  input  logic       in_key_raw,
  input  logic       in_timer_select,
  input  logic       in_cpu_halted,
  input  logic [1:0] in_partner_lines,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_read_data,
  output logic [3:0] out_bank_one,
  output logic [3:0] out_bank_two,
  output logic [3:0] out_bank_three,
  output logic       out_writable_one,
  output logic       out_writable_two,
  output logic       out_writable_three,
  output logic       out_interrupt_request
);
  import hiopc_pkg::*;

  logic q_valid, q_take;
  req_t q_req;

  hiopc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_port_number,
    .in_write_value, .in_key_code, .in_key_pressed, .in_key_raw,
    .in_timer_select, .in_cpu_halted, .in_partner_lines,
    .q_valid, .q_req, .q_take
  );

  hiopc_back #(.KEY_ROWS(KEY_ROWS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_link_variant, .q_valid, .q_req, .q_take,
    .out_empty, .out_pop, .out_read_data, .out_bank_one, .out_bank_two,
    .out_bank_three, .out_writable_one, .out_writable_two,
    .out_writable_three, .out_interrupt_request
  );
endmodule

// ----- design/hiopc_checker.sv -----
module hiopc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [3:0] out_bank_three
);
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result pending after reset");
  a_not_full_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_full) else $error("queue full after reset");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> ##1 !out_empty) else $error("request lost");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("result dropped");
  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_bank_three <= 4'd9)) else $error("bank out of range");
endmodule

bind handheld_io_port_controller_core hiopc_checker u_checker (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop,
  .out_bank_three
);
